/* sv/onewire_search_rom_engine_core_defines.svh */
// onewire_search_rom_engine_core_defines.svh
// assertion macros shared by the search rom engine checker
// expects clock and reset to be visible where a macro is used
`ifndef ONEWIRE_SEARCH_ROM_ENGINE_CORE_DEFINES_SVH
`define ONEWIRE_SEARCH_ROM_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define OWSRE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define OWSRE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define OWSRE_ASSERT_RAW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/owsre_pkg.sv */
// owsre_pkg.sv
// shared types, codes and the crc step of the search rom engine
// no dependencies
package owsre_pkg;

   // operation codes
   localparam logic [1:0] OpNewSearch = 2'd0;
   localparam logic [1:0] OpStartPass = 2'd1;
   localparam logic [1:0] OpBitPair   = 2'd2;

   // status codes
   localparam logic [2:0] StatusInProgress = 3'd0;
   localparam logic [2:0] StatusFound      = 3'd1;
   localparam logic [2:0] StatusNoPresence = 3'd2;
   localparam logic [2:0] StatusReadError  = 3'd3;
   localparam logic [2:0] StatusCrcError   = 3'd4;

   localparam int CodeWidth = 64;
   localparam int PosWidth  = 7;
   localparam int IdxWidth  = 6;
   localparam int CrcWidth  = 8;

   // last bit position, and last position that feeds the crc
   localparam logic [PosWidth-1:0] LastPos    = 7'd64;
   localparam logic [PosWidth-1:0] LastCrcPos = 7'd56;
   localparam logic [PosWidth-1:0] FirstPos   = 7'd1;

   // reflected dallas crc-8 polynomial
   localparam logic [CrcWidth-1:0] CrcPoly = 8'h8C;

   typedef struct packed {
      logic [1:0] operation;
      logic       presence;
      logic       bit_a;
      logic       bit_b;
   } item_type;

   typedef struct packed {
      logic                 write_bit;
      logic [2:0]           status;
      logic [CodeWidth-1:0] rom_code;
      logic                 search_done;
   } result_type;

   // one bit of the crc, lsb first
   function automatic logic [CrcWidth-1:0] crc_step(logic [CrcWidth-1:0] crc, logic data_bit);
      logic fb;
      fb = data_bit ^ crc[0];
      return (crc >> 1) ^ (fb ? CrcPoly : '0);
   endfunction

endpackage

/* sv/owsre_walk.sv */
// owsre_walk.sv
// search state registers and the per-item decision logic
// depends on owsre_pkg
module owsre_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_fire,
   input  owsre_pkg::item_type   item,
   output owsre_pkg::result_type result
);

   typedef struct packed {
      logic [owsre_pkg::CodeWidth-1:0] code_bits;
      logic [owsre_pkg::PosWidth-1:0]  last_disc;
      logic [owsre_pkg::PosWidth-1:0]  disc_mark;
      logic [owsre_pkg::PosWidth-1:0]  position;
      logic [owsre_pkg::CrcWidth-1:0]  crc;
      logic                            in_pass;
      logic                            finished;
   } walk_state_type;

   localparam walk_state_type ResetState = '{
      code_bits: '0,
      last_disc: '0,
      disc_mark: '0,
      position:  owsre_pkg::FirstPos,
      crc:       '0,
      in_pass:   1'b0,
      finished:  1'b0
   };

   walk_state_type state_ff, state_in;

   logic [owsre_pkg::IdxWidth-1:0]  idx;
   logic                            stored;
   logic                            chosen;
   logic                            mark_here;
   logic [owsre_pkg::CodeWidth-1:0] code_upd;
   logic [owsre_pkg::CrcWidth-1:0]  crc_upd;

   // direction choice for the current position
   always_comb begin
      idx       = owsre_pkg::IdxWidth'(state_ff.position - owsre_pkg::FirstPos);
      stored    = state_ff.code_bits[idx];
      mark_here = 1'b0;
      if (item.bit_a | item.bit_b) begin
         chosen = item.bit_a;
      end else if (state_ff.position == state_ff.last_disc) begin
         chosen = 1'b1;
      end else if (state_ff.position > state_ff.last_disc) begin
         chosen    = 1'b0;
         mark_here = 1'b1;
      end else begin
         chosen    = stored;
         mark_here = ~stored;
      end
      code_upd      = state_ff.code_bits;
      code_upd[idx] = chosen;
      crc_upd       = (state_ff.position <= owsre_pkg::LastCrcPos) ?
                      owsre_pkg::crc_step(state_ff.crc, chosen) : state_ff.crc;
   end

   // next state and result
   always_comb begin
      state_in = state_ff;
      result   = '0;
      result.status = owsre_pkg::StatusInProgress;
      case (item.operation)
         owsre_pkg::OpNewSearch: begin
            state_in = ResetState;
         end
         owsre_pkg::OpStartPass: begin
            if (!item.presence) begin
               state_in.in_pass = 1'b0;
               result.status    = owsre_pkg::StatusNoPresence;
            end else begin
               state_in.position  = owsre_pkg::FirstPos;
               state_in.disc_mark = '0;
               state_in.crc       = '0;
               state_in.in_pass   = 1'b1;
               state_in.finished  = 1'b0;
            end
         end
         owsre_pkg::OpBitPair: begin
            if (state_ff.in_pass) begin
               if (item.bit_a & item.bit_b) begin
                  state_in.in_pass   = 1'b0;
                  state_in.disc_mark = '0;
                  state_in.last_disc = '0;
                  state_in.finished  = 1'b0;
                  result.status      = owsre_pkg::StatusReadError;
               end else begin
                  state_in.code_bits = code_upd;
                  state_in.crc       = crc_upd;
                  result.write_bit   = chosen;
                  if (mark_here) begin
                     state_in.disc_mark = state_ff.position;
                  end
                  if (state_ff.position >= owsre_pkg::LastPos) begin
                     state_in.in_pass   = 1'b0;
                     state_in.last_disc = state_in.disc_mark;
                     state_in.finished  = (state_in.disc_mark == '0);
                     state_in.position  = owsre_pkg::FirstPos;
                     result.rom_code    = code_upd;
                     result.status      =
                        (code_upd[owsre_pkg::CodeWidth-1 -: owsre_pkg::CrcWidth] == crc_upd) ?
                        owsre_pkg::StatusFound : owsre_pkg::StatusCrcError;
                  end else begin
                     state_in.position = state_ff.position + owsre_pkg::FirstPos;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      result.search_done = state_in.finished;
   end

   // search state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ResetState;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/owsre_rsp_reg.sv */
// owsre_rsp_reg.sv
// result register with valid flag in front of the rsp channel
// depends on owsre_pkg
module owsre_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  owsre_pkg::result_type result,
   input  logic                  rsp_tready,
   output logic                  rsp_valid,
   output owsre_pkg::result_type rsp_result,
   output logic                  rsp_free
);

   logic                  valid_ff, valid_in;
   owsre_pkg::result_type result_ff;

   // slot frees when empty or when the held result is taken
   assign rsp_free = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

/* sv/onewire_search_rom_engine_core.sv */
// onewire_search_rom_engine_core.sv
// top level of the 1-wire search rom decision engine
// depends on owsre_pkg, owsre_walk, owsre_rsp_reg
//
//   channel | direction | contents
//   req     | in        | one command or one read bit pair per transaction
//   rsp     | out       | one result per request transaction
//
// one transaction per cycle is accepted in steady state, while the rsp side is not stalled
// each item passes through an input register, then the result register
// the search state updates as an item moves from input to result register
// a stalled rsp side holds one result and one more request, then req_tready drops
// synchronous active-high reset clears the search state and both valid flags
module onewire_search_rom_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // presence, bit_a, bit_b, zero fill
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // write_bit, rom_code[63:0], search_done, zero fill
   output logic [2:0]  rsp_tuser    // status
);

   logic                  in_valid_ff, in_valid_in;
   owsre_pkg::item_type   in_item_ff;
   logic                  req_fire;
   logic                  step_fire;
   logic                  rsp_free;
   owsre_pkg::result_type step_result;
   owsre_pkg::result_type rsp_result;

   // handshake: item advances when the result slot is free
   assign step_fire  = in_valid_ff & rsp_free;
   assign req_tready = ~in_valid_ff | rsp_free;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.operation <= req_tuser;
         in_item_ff.presence  <= req_tdata[0];
         in_item_ff.bit_a     <= req_tdata[1];
         in_item_ff.bit_b     <= req_tdata[2];
      end
   end

   owsre_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .item      (in_item_ff),
      .result    (step_result)
   );

   owsre_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step_fire),
      .result     (step_result),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (rsp_result),
      .rsp_free   (rsp_free)
   );

   // result packing
   assign rsp_tdata = {6'b0, rsp_result.search_done, rsp_result.rom_code, rsp_result.write_bit};
   assign rsp_tuser = rsp_result.status;

endmodule

/* sv/owsre_checker.sv */
// owsre_checker.sv
// port-level checks of the search rom engine, bound to the top level
// depends on owsre_pkg and onewire_search_rom_engine_core_defines.svh
`include "onewire_search_rom_engine_core_defines.svh"

module owsre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a code is only shown with a completed pass
   `OWSRE_ASSERT_NOW(a_code_only_at_end, rsp_tvalid && rsp_tuser != owsre_pkg::StatusFound && rsp_tuser != owsre_pkg::StatusCrcError, rsp_tdata[64:1] == 64'd0, "rom code shown without a completed pass")

   // a direction bit only comes from a clean bit pair
   `OWSRE_ASSERT_NOW(a_write_bit_status, rsp_tvalid && rsp_tdata[0], rsp_tuser == owsre_pkg::StatusInProgress || rsp_tuser == owsre_pkg::StatusFound || rsp_tuser == owsre_pkg::StatusCrcError, "write bit with an error status")

   // no result right after reset
   `OWSRE_ASSERT_RAW(a_reset_empty, reset, !rsp_tvalid, "result valid after reset")

   // a stalled result holds
   `OWSRE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind onewire_search_rom_engine_core owsre_checker u_owsre_checker (.*);
